[hdl/lhhm_pkg.sv]
package lhhm_pkg;

    localparam int INDEX_BITS      = 5;
    localparam int WEIGHT_OUT_BITS = 37;

    localparam logic [7:0] UPPER_A = 8'h41;
    localparam logic [7:0] UPPER_Z = 8'h5A;
    localparam logic [7:0] LOWER_A = 8'h61;
    localparam logic [7:0] LOWER_Z = 8'h7A;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_word_t;

    typedef struct packed {
        logic                       merge_valid;
        logic [INDEX_BITS-1:0]      kept_index;
        logic [INDEX_BITS-1:0]      retired_index;
        logic [WEIGHT_OUT_BITS-1:0] merged_weight;
        logic                       final_merge;
    } out_word_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic count_en;
        logic scan_en;
        logic merge_en;
        logic emit_none;
        logic clear_en;
    } ctrl_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic few_trees;
        logic last_pair;
        logic scan_last;
    } ctrl_status_t;

endpackage

[hdl/lhhm_datapath.sv]
module lhhm_datapath
    import lhhm_pkg::*;
#(
    parameter int COUNT_BITS    = 32,
    parameter int ALPHABET_SIZE = 26
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  in_word_t     text,
    input  ctrl_cmd_t    cmd,
    output ctrl_status_t status,
    output logic         result_valid,
    output out_word_t    result
);

    localparam int IW    = $clog2(ALPHABET_SIZE);
    localparam int WB    = COUNT_BITS + 5;
    localparam int EW    = (WB > WEIGHT_OUT_BITS) ? WB : WEIGHT_OUT_BITS;
    localparam int CNT_W = $clog2(ALPHABET_SIZE + 1);

    logic [WB-1:0]    weight_reg [ALPHABET_SIZE];
    logic             active_reg [ALPHABET_SIZE];
    logic [CNT_W-1:0] tree_cnt_reg;
    logic [IW-1:0]    scan_idx_reg;

    logic [WB-1:0]    m1w_reg, m2w_reg;
    logic [IW-1:0]    m1i_reg, m2i_reg;
    logic             m1v_reg, m2v_reg;
    logic [WB-1:0]    m1w_next, m2w_next;
    logic [IW-1:0]    m1i_next, m2i_next;
    logic             m1v_next, m2v_next;

    logic             result_valid_reg;
    out_word_t        result_reg;

    // Letter decode.
    logic [7:0]    byte_v;
    logic          is_lower, is_upper;
    logic [7:0]    offset;
    logic          slot_hit;
    logic [IW-1:0] slot_idx;
    logic          count_sat;

    always_comb
    begin
        byte_v    = text.text_byte;
        is_lower  = (byte_v >= LOWER_A) && (byte_v <= LOWER_Z);
        is_upper  = (byte_v >= UPPER_A) && (byte_v <= UPPER_Z);
        offset    = is_lower ? (byte_v - LOWER_A) : (byte_v - UPPER_A);
        slot_hit  = (is_lower || is_upper) && (offset < 8'(ALPHABET_SIZE));
        slot_idx  = offset[IW-1:0];
        count_sat = slot_hit && (&weight_reg[slot_idx][COUNT_BITS-1:0]);
    end

    // Two-smallest search, one slot per cycle while scan_en is set, in ascending order. Strict
    // compares keep the lowest index on ties.
    logic [WB-1:0] cur_w;
    logic          cur_act;
    logic          h1v, h2v;

    always_comb
    begin
        cur_w    = weight_reg[scan_idx_reg];
        cur_act  = active_reg[scan_idx_reg];
        h1v      = (scan_idx_reg != '0) && m1v_reg;
        h2v      = (scan_idx_reg != '0) && m2v_reg;
        m1w_next = m1w_reg;
        m1i_next = m1i_reg;
        m1v_next = h1v;
        m2w_next = m2w_reg;
        m2i_next = m2i_reg;
        m2v_next = h2v;
        if (cur_act)
        begin
            if (!h1v || (cur_w < m1w_reg))
            begin
                m2w_next = m1w_reg;
                m2i_next = m1i_reg;
                m2v_next = h1v;
                m1w_next = cur_w;
                m1i_next = scan_idx_reg;
                m1v_next = 1'b1;
            end
            else if (!h2v || (cur_w < m2w_reg))
            begin
                m2w_next = cur_w;
                m2i_next = scan_idx_reg;
                m2v_next = 1'b1;
            end
        end
    end

    logic [WB-1:0] sum;
    logic [EW-1:0] sum_ext;
    logic [WEIGHT_OUT_BITS-1:0] sum_out;

    always_comb
    begin
        sum     = m1w_reg + m2w_reg;
        sum_ext = EW'(sum);
        sum_out = (sum_ext > EW'({WEIGHT_OUT_BITS{1'b1}})) ? {WEIGHT_OUT_BITS{1'b1}}
                                                           : sum_ext[WEIGHT_OUT_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ALPHABET_SIZE; i++)
            begin
                weight_reg[i] <= '0;
                active_reg[i] <= 1'b0;
            end
            tree_cnt_reg <= '0;
        end
        else if (cmd.clear_en)
        begin
            for (int i = 0; i < ALPHABET_SIZE; i++)
            begin
                weight_reg[i] <= '0;
                active_reg[i] <= 1'b0;
            end
            tree_cnt_reg <= '0;
        end
        else if (cmd.merge_en)
        begin
            weight_reg[m1i_reg] <= sum;
            weight_reg[m2i_reg] <= '0;
            active_reg[m2i_reg] <= 1'b0;
            tree_cnt_reg        <= tree_cnt_reg - CNT_W'(1);
        end
        else if (cmd.count_en && slot_hit)
        begin
            if (!count_sat)
            begin
                weight_reg[slot_idx] <= weight_reg[slot_idx] + WB'(1);
            end
            if (!active_reg[slot_idx])
            begin
                active_reg[slot_idx] <= 1'b1;
                tree_cnt_reg         <= tree_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            m1v_reg      <= 1'b0;
            m2v_reg      <= 1'b0;
        end
        else if (cmd.scan_en)
        begin
            scan_idx_reg <= (scan_idx_reg == IW'(ALPHABET_SIZE - 1)) ? '0
                                                                     : scan_idx_reg + IW'(1);
            m1v_reg      <= m1v_next;
            m2v_reg      <= m2v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_en)
        begin
            m1w_reg <= m1w_next;
            m1i_reg <= m1i_next;
            m2w_reg <= m2w_next;
            m2i_reg <= m2i_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.merge_en || cmd.emit_none;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.merge_en)
        begin
            result_reg.merge_valid   <= 1'b1;
            result_reg.kept_index    <= INDEX_BITS'(m1i_reg);
            result_reg.retired_index <= INDEX_BITS'(m2i_reg);
            result_reg.merged_weight <= sum_out;
            result_reg.final_merge   <= (tree_cnt_reg == CNT_W'(2));
        end
        else if (cmd.emit_none)
        begin
            result_reg.merge_valid   <= 1'b0;
            result_reg.kept_index    <= '0;
            result_reg.retired_index <= '0;
            result_reg.merged_weight <= '0;
            result_reg.final_merge   <= 1'b1;
        end
    end

    assign status.few_trees = (tree_cnt_reg < CNT_W'(2));
    assign status.last_pair = (tree_cnt_reg == CNT_W'(2));
    assign status.scan_last = (scan_idx_reg == IW'(ALPHABET_SIZE - 1));
    assign result_valid     = result_valid_reg;
    assign result           = result_reg;

endmodule

[hdl/lhhm_ctrl.sv]
module lhhm_ctrl
    import lhhm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         end_of_text,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd,
    output logic         busy
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_MERGE = 3'd3;
    localparam logic [2:0] ST_CLEAR = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.count_en = 1'b1;
                    if (end_of_text)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (status.few_trees)
                begin
                    cmd.emit_none = 1'b1;
                    state_next    = ST_CLEAR;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                cmd.merge_en = 1'b1;
                state_next   = status.last_pair ? ST_CLEAR : ST_SCAN;
            end
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

[hdl/letter_histogram_huffman_merge.sv]
// Counts the letters A-Z of a byte stream without regard to case and, after the
// word marked end_of_text, emits the Huffman merges over the letters seen, one
// result word per merge with final_merge set on the last one (or a single word
// with merge_valid clear when fewer than two letters were seen). Results appear
// for exactly one cycle with result_valid high and cannot be stalled, so the
// receiver must take every word as it comes. While counting, one byte is taken
// per cycle. After the last byte the block stays busy for the merge run: a check
// state, then per merge a scan of the weight table, one slot per cycle, that
// finds the two smallest trees, then the merge itself, and last a state that
// clears the table.
module letter_histogram_huffman_merge
    import lhhm_pkg::*;
#(
    parameter int COUNT_BITS    = 32,
    parameter int ALPHABET_SIZE = 26
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_word_t  text,
    output logic      result_valid,
    output out_word_t result
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    lhhm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .end_of_text (text.end_of_text),
        .status      (status),
        .cmd         (cmd),
        .busy        (busy)
    );

    lhhm_datapath #(
        .COUNT_BITS    (COUNT_BITS),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .text         (text),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

[tb/sv/letter_histogram_huffman_merge_tb.sv]
`timescale 1ns / 100ps

module letter_histogram_huffman_merge_tb
    import lhhm_pkg::*;
();

    localparam int          COUNT_BITS   = 32;
    localparam int          ALPHABET     = 26;
    localparam int          MAX_MERGES   = 25;
    localparam logic [63:0] COUNT_MAX    = (64'd1 << COUNT_BITS) - 64'd1;
    localparam logic [63:0] WEIGHT_MAX   = (64'd1 << WEIGHT_OUT_BITS) - 64'd1;
    localparam int          RANDOM_WORDS = 186;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 30;
    localparam int          SHOW_LIMIT   = 10;

    localparam out_word_t NO_MERGE = '{1'b0, 5'd0, 5'd0, 37'd0, 1'b1};
    localparam out_word_t AB_MERGE = '{1'b1, 5'd0, 5'd1, 37'd2, 1'b1};
    localparam out_word_t UNFIXED  = '0;

    // One row of the directed part. Rows with fixed set carry their expected
    // word; all other rows are checked against the tally model below.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       fixed;
        out_word_t  want;
    } plan_row_t;

    localparam int PLAN_ROWS = 24;
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{"A",   1'b1, 1'b1, NO_MERGE},
        '{8'h00, 1'b1, 1'b1, NO_MERGE},
        '{8'hFF, 1'b1, 1'b1, NO_MERGE},
        '{"a",   1'b0, 1'b0, UNFIXED},
        '{"B",   1'b1, 1'b1, AB_MERGE},
        '{8'h40, 1'b0, 1'b0, UNFIXED},
        '{8'h5B, 1'b0, 1'b0, UNFIXED},
        '{8'h60, 1'b0, 1'b0, UNFIXED},
        '{8'h7B, 1'b0, 1'b0, UNFIXED},
        '{"Z",   1'b0, 1'b0, UNFIXED},
        '{"z",   1'b1, 1'b1, NO_MERGE},
        '{"M",   1'b0, 1'b0, UNFIXED},
        '{"m",   1'b0, 1'b0, UNFIXED},
        '{"q",   1'b0, 1'b0, UNFIXED},
        '{"c",   1'b1, 1'b0, UNFIXED},
        '{8'h80, 1'b0, 1'b0, UNFIXED},
        '{8'h7F, 1'b0, 1'b0, UNFIXED},
        '{"Y",   1'b0, 1'b0, UNFIXED},
        '{"y",   1'b0, 1'b0, UNFIXED},
        '{"e",   1'b0, 1'b0, UNFIXED},
        '{"Y",   1'b0, 1'b0, UNFIXED},
        '{"k",   1'b0, 1'b0, UNFIXED},
        '{"k",   1'b0, 1'b0, UNFIXED},
        '{"E",   1'b1, 1'b0, UNFIXED}
    };

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_word_t  text;
    logic      result_valid;
    out_word_t result;

    logic [63:0] tree_wt   [ALPHABET];
    logic        tree_live [ALPHABET];
    out_word_t   step_merges [$];
    out_word_t   merges_due  [$];
    int          fail_count;
    int          stall_cycles;

    letter_histogram_huffman_merge #(
        .COUNT_BITS    (COUNT_BITS),
        .ALPHABET_SIZE (ALPHABET)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .text         (text),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Lowest-index live tree of smallest weight, not counting slot skip.
    function automatic int lightest_tree(int skip);
        int pick;
        pick = -1;
        for (int i = 0; i < ALPHABET; i++)
        begin
            if (tree_live[i] && i != skip && (pick < 0 || tree_wt[i] < tree_wt[pick]))
                pick = i;
        end
        return pick;
    endfunction

    // Counts one byte and, on the last byte of a text, runs the merges and
    // leaves the words they produce in step_merges.
    task automatic tally_and_merge(input in_word_t w);
        int          slot;
        int          a;
        int          b;
        logic [63:0] sum;
        out_word_t   m;
        slot = -1;
        step_merges.delete();
        if (w.text_byte >= LOWER_A && w.text_byte <= LOWER_Z)
            slot = int'(w.text_byte - LOWER_A);
        else if (w.text_byte >= UPPER_A && w.text_byte <= UPPER_Z)
            slot = int'(w.text_byte - UPPER_A);
        if (slot >= 0 && slot < ALPHABET)
        begin
            if (tree_wt[slot] < COUNT_MAX)
                tree_wt[slot] = tree_wt[slot] + 64'd1;
            tree_live[slot] = 1'b1;
        end
        if (!w.end_of_text)
            return;
        while (1)
        begin
            a = lightest_tree(-1);
            b = (a < 0) ? -1 : lightest_tree(a);
            if (b < 0 || step_merges.size() >= MAX_MERGES)
                break;
            sum = tree_wt[a] + tree_wt[b];
            tree_wt[a] = sum;
            tree_wt[b] = 64'd0;
            tree_live[b] = 1'b0;
            m.merge_valid   = 1'b1;
            m.kept_index    = a[INDEX_BITS-1:0];
            m.retired_index = b[INDEX_BITS-1:0];
            m.merged_weight = (sum > WEIGHT_MAX) ? WEIGHT_MAX[WEIGHT_OUT_BITS-1:0]
                                                 : sum[WEIGHT_OUT_BITS-1:0];
            m.final_merge   = 1'b0;
            step_merges.push_back(m);
        end
        if (step_merges.size() == 0)
            step_merges.push_back(NO_MERGE);
        else
            step_merges[step_merges.size()-1].final_merge = 1'b1;
        for (int i = 0; i < ALPHABET; i++)
        begin
            tree_wt[i]   = 64'd0;
            tree_live[i] = 1'b0;
        end
    endtask

    // Offers one word after a random gap and books what it should produce.
    // start stays high on return, so back-to-back words need not drop and raise it again.
    task automatic send_word(input in_word_t w, input int idle_pct,
                             input logic fixed, input out_word_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        text  <= w;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        tally_and_merge(w);
        if (fixed)
        begin
            if (w.end_of_text)
                merges_due.push_back(want);
        end
        else
        begin
            foreach (step_merges[i])
                merges_due.push_back(step_merges[i]);
        end
    endtask

    function automatic logic [7:0] letter_byte(int idx);
        return ($urandom_range(1) ? LOWER_A : UPPER_A) + 8'(idx);
    endfunction

    function automatic logic [7:0] text_char(int noise_pct);
        if ($urandom_range(99) < noise_pct)
            return 8'($urandom_range(255));
        return letter_byte($urandom_range(ALPHABET - 1));
    endfunction

    task automatic report_mismatch(input string what, input out_word_t want,
                                   input out_word_t got);
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
            $display("%0t %s: exp %0b/%0d/%0d/%0d/%0b got %0b/%0d/%0d/%0d/%0b",
                     $realtime, what,
                     want.merge_valid, want.kept_index, want.retired_index,
                     want.merged_weight, want.final_merge,
                     got.merge_valid, got.kept_index, got.retired_index,
                     got.merged_weight, got.final_merge);
    endtask

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && result_valid)
        begin
            if (merges_due.size() == 0)
                report_mismatch("unexpected merge word", '0, result);
            else
            begin
                want = merges_due.pop_front();
                if (result.merge_valid   !== want.merge_valid   ||
                    result.kept_index    !== want.kept_index    ||
                    result.retired_index !== want.retired_index ||
                    result.merged_weight !== want.merged_weight ||
                    result.final_merge   !== want.final_merge)
                    report_mismatch("merge word mismatch", want, result);
            end
        end
    end

    // Counts cycles in which no word moves in either direction.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog expired with %0d merge words outstanding", merges_due.size());
            $display("FAIL letter_histogram_huffman_merge");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        in_word_t   w;
        logic [7:0] run [$];
        int         kind;
        int         len;
        int         idle_pct;
        int         words_done;

        rst_n        <= 1'b0;
        start        <= 1'b0;
        text         <= '0;
        fail_count   = 0;
        words_done   = 0;
        for (int i = 0; i < ALPHABET; i++)
        begin
            tree_wt[i]   = 64'd0;
            tree_live[i] = 1'b0;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            w.text_byte   = PLAN[i].ch;
            w.end_of_text = PLAN[i].last;
            send_word(w, 35, PLAN[i].fixed, PLAN[i].want);
        end

        // Random texts: mostly letters with some noise bytes, a few very short
        // texts, and now and then one that holds every letter.
        while (words_done < RANDOM_WORDS)
        begin
            run.delete();
            kind = $urandom_range(99);
            if (kind < 10)
            begin
                for (int i = 0; i < ALPHABET; i++)
                begin
                    len = $urandom_range(2, 1);
                    repeat (len) run.push_back(letter_byte(i));
                end
                len = $urandom_range(4);
                repeat (len) run.push_back(text_char(50));
            end
            else if (kind < 25)
            begin
                len = $urandom_range(2, 1);
                repeat (len) run.push_back(text_char(30));
            end
            else
            begin
                len = $urandom_range(12, 3);
                repeat (len) run.push_back(text_char(20));
            end

            foreach (run[i])
            begin
                idle_pct = (words_done < RANDOM_WORDS / 3)     ? 35 :
                           (words_done < 2 * RANDOM_WORDS / 3) ? 83 : 0;
                w.text_byte   = run[i];
                w.end_of_text = (i == run.size() - 1);
                send_word(w, idle_pct, 1'b0, UNFIXED);
                words_done++;
            end
        end
        start <= 1'b0;

        while (merges_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("PASS letter_histogram_huffman_merge");
        else
            $display("FAIL letter_histogram_huffman_merge");
        $finish;
    end

endmodule
